FILE: src/ttcs_pkg.sv
package ttcs_pkg;

   // field widths
   localparam int POS_W   = 24;
   localparam int DIFF_W  = POS_W + 1;
   localparam int HEAD_W  = 16;
   localparam int ID_W    = 16;
   localparam int TW_W    = 10;
   localparam int COST_W  = 25;

   // square root: 50-bit radicand, one result bit per step
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int ROOT_W     = SQRT_STEPS;

   // CORDIC datapath: operand scaled by 2^30, headroom for the gain
   localparam int CORDIC_SCALE = 30;
   localparam int CW           = DIFF_W + CORDIC_SCALE + 2;
   localparam int ANG_W        = 32;
   localparam int ATAN_N       = 24;

   localparam logic [ANG_W-1:0] Z_QUARTER     = 32'h4000_0000;
   localparam logic [ANG_W-1:0] Z_3QUARTER    = 32'hC000_0000;
   localparam logic [ANG_W-1:0] ANG_HALF_LSB  = 32'h0000_8000;

   // heading error and penalty
   localparam int ERR_W       = HEAD_W + 1;
   localparam int ERRW_W      = ERR_W + TW_W;
   localparam int PEN_SCALE_W = 9;
   localparam int PEN_W       = ERRW_W + PEN_SCALE_W;
   localparam int PEN_SHIFT   = 16;

   localparam logic [ERR_W-1:0]  ANG16_TURN = 17'h1_0000;
   localparam logic [PEN_W-1:0]  PEN_SCALE  = 36'd360;
   localparam logic [TW_W-1:0]   TW_RESET   = 10'd128;

   localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_N] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   function automatic logic [ANG_W-1:0] ttcs_atan(input int idx);
      logic [ANG_W-1:0] r;
      r = '0;
      if (idx >= 0 && idx < ATAN_N) begin
         r = ATAN_TAB[idx];
      end
      return r;
   endfunction

   // one beat in flight through the root / CORDIC chain
   typedef struct packed {
      logic [SQ_W-1:0]          rem;
      logic [SQ_W-1:0]          root;
      logic signed [CW-1:0]     cx;
      logic signed [CW-1:0]     cy;
      logic [ANG_W-1:0]         cz;
      logic                     zero;
      logic [HEAD_W-1:0]        heading;
      logic [ID_W-1:0]          id;
   } ttcs_chain_type;

endpackage

FILE: src/ttcs_if.sv
interface ttcs_req_if import ttcs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  agent_x;
   logic signed [POS_W-1:0]  agent_y;
   logic [HEAD_W-1:0]        agent_heading;
   logic signed [POS_W-1:0]  target_x;
   logic signed [POS_W-1:0]  target_y;
   logic [ID_W-1:0]          target_id;
   logic                     already_claimed;

   modport source (
      output valid, agent_x, agent_y, agent_heading, target_x, target_y,
             target_id, already_claimed,
      input  ready
   );
   modport sink (
      input  valid, agent_x, agent_y, agent_heading, target_x, target_y,
             target_id, already_claimed,
      output ready
   );
endinterface

interface ttcs_rsp_if import ttcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     scored_id;
   logic [COST_W-1:0]   travel_cost;

   modport source (
      output valid, scored_id, travel_cost,
      input  ready
   );
   modport sink (
      input  valid, scored_id, travel_cost,
      output ready
   );
endinterface

FILE: src/task_travel_cost_scorer_unit.sv
// Channel  | Dir | Handshake          | Beat contents
// ---------+-----+--------------------+--------------------------------------------------
// req_bus  | in  | valid/ready        | agent pose, task point, target_id, already_claimed
// rsp_bus  | out | valid/ready        | scored_id, travel_cost (Q17.8 m)
// csr_*    | in  | write enable only  | turn_weight (Q2.8 m per degree)
//
// One beat per cycle sustained while the skid is empty. There are 30 register stages:
// difference, square, pre-rotate, 25 root/CORDIC steps, error*weight, output register.
// The 25-step root chain sets the depth; CORDIC rides on its first CORDIC_STEPS steps.
// Synchronous active-high reset clears valid bits and loads turn_weight with 0.5.
// A stalled result parks in a one-entry skid; the whole pipe holds only while it is full.
// Claimed tasks are accepted and dropped at the first stage.
module task_travel_cost_scorer_unit import ttcs_pkg::*; #(
   parameter int CORDIC_STEPS = 18
) (
   input  logic              clock,
   input  logic              reset,
   ttcs_req_if.sink          req_bus,
   ttcs_rsp_if.source        rsp_bus,
   input  logic              csr_write_en,
   input  logic [TW_W-1:0]   csr_write_data
);

   // ---------------------------------------------------------------
   // Flow control: everything advances unless the skid holds a beat.
   // ---------------------------------------------------------------
   logic advance;
   logic req_accept;

   logic skid_valid_ff, skid_valid_in;
   logic rsp_valid_ff,  rsp_valid_in;

   assign advance       = !skid_valid_ff;
   assign req_bus.ready = advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // turn weight register; it must be only written while the pipe is empty, which the user ensures
   logic [TW_W-1:0] tw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= TW_RESET;
      end else if (csr_write_en) begin
         tw_ff <= csr_write_data;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: position differences. Claimed tasks become bubbles here.
   // ---------------------------------------------------------------
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [DIFF_W-1:0]   s1_dx_ff, s1_dx_in;
   logic signed [DIFF_W-1:0]   s1_dy_ff, s1_dy_in;
   logic [HEAD_W-1:0]          s1_head_ff;
   logic [ID_W-1:0]            s1_id_ff;

   assign s1_valid_in = req_accept && !req_bus.already_claimed;
   assign s1_dx_in    = {req_bus.target_x[POS_W-1], req_bus.target_x}
                      - {req_bus.agent_x[POS_W-1],  req_bus.agent_x};
   assign s1_dy_in    = {req_bus.target_y[POS_W-1], req_bus.target_y}
                      - {req_bus.agent_y[POS_W-1],  req_bus.agent_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_head_ff <= req_bus.agent_heading;
         s1_id_ff   <= req_bus.target_id;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: squares for the radicand, zero-vector flag.
   // ---------------------------------------------------------------
   logic                       s2_valid_ff;
   logic signed [SQ_W-1:0]     sqx_full;
   logic signed [SQ_W-1:0]     sqy_full;
   logic [SQ_W-1:0]            s2_sqx_ff;
   logic [SQ_W-1:0]            s2_sqy_ff;
   logic signed [DIFF_W-1:0]   s2_dx_ff;
   logic signed [DIFF_W-1:0]   s2_dy_ff;
   logic                       s2_zero_ff, s2_zero_in;
   logic [HEAD_W-1:0]          s2_head_ff;
   logic [ID_W-1:0]            s2_id_ff;

   assign sqx_full   = s1_dx_ff * s1_dx_ff;
   assign sqy_full   = s1_dy_ff * s1_dy_ff;
   assign s2_zero_in = (s1_dx_ff == '0) && (s1_dy_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sqx_ff  <= unsigned'(sqx_full);
         s2_sqy_ff  <= unsigned'(sqy_full);
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_zero_ff <= s2_zero_in;
         s2_head_ff <= s1_head_ff;
         s2_id_ff   <= s1_id_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: radicand sum and quadrant pre-rotation into the right
   // half plane (+90 or -90 degrees when x is negative).
   // ---------------------------------------------------------------
   logic                   s3_valid_ff;
   ttcs_chain_type         s3_ff, s3_in;
   logic signed [CW-1:0]   x0;
   logic signed [CW-1:0]   y0;

   assign x0 = CW'(s2_dx_ff) <<< CORDIC_SCALE;
   assign y0 = CW'(s2_dy_ff) <<< CORDIC_SCALE;

   always_comb begin
      s3_in.rem     = s2_sqx_ff + s2_sqy_ff;
      s3_in.root    = '0;
      s3_in.zero    = s2_zero_ff;
      s3_in.heading = s2_head_ff;
      s3_in.id      = s2_id_ff;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            s3_in.cx = y0;
            s3_in.cy = -x0;
            s3_in.cz = Z_QUARTER;
         end else begin
            s3_in.cx = -y0;
            s3_in.cy = x0;
            s3_in.cz = Z_3QUARTER;
         end
      end else begin
         s3_in.cx = x0;
         s3_in.cy = y0;
         s3_in.cz = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------------
   // Root / CORDIC chain: one registered step per root bit. The first
   // CORDIC_STEPS steps also rotate; the rest carry the angle along.
   // ---------------------------------------------------------------
   logic           chain_valid [SQRT_STEPS+1];
   ttcs_chain_type chain_d     [SQRT_STEPS+1];

   assign chain_valid[0] = s3_valid_ff;
   assign chain_d[0]     = s3_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_chain
      ttcs_step #(
         .STEP   (k),
         .ROTATE (k < CORDIC_STEPS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (chain_valid[k]),
         .d        (chain_d[k]),
         .valid_ff (chain_valid[k+1]),
         .q_ff     (chain_d[k+1])
      );
   end

   // ---------------------------------------------------------------
   // Stage 4: round bearing to 16 bits, fold heading error to a half
   // turn, multiply by the turn weight.
   // ---------------------------------------------------------------
   ttcs_chain_type         fin;
   logic [ANG_W-1:0]       ang_rnd;
   logic [HEAD_W-1:0]      bearing;
   logic [HEAD_W-1:0]      diff;
   logic [ERR_W-1:0]       err;
   logic                   s4_valid_ff;
   logic [ERRW_W-1:0]      s4_errw_ff, s4_errw_in;
   logic [ROOT_W-1:0]      s4_root_ff;
   logic [ID_W-1:0]        s4_id_ff;

   assign fin        = chain_d[SQRT_STEPS];
   assign ang_rnd    = fin.cz + ANG_HALF_LSB;
   assign bearing    = fin.zero ? '0 : ang_rnd[ANG_W-1:ANG_W-HEAD_W];
   assign diff       = bearing - fin.heading;
   // half-turn error (0x8000) folds onto itself
   assign err        = diff[HEAD_W-1] ? (ANG16_TURN - {1'b0, diff}) : {1'b0, diff};
   assign s4_errw_in = ERRW_W'(err) * ERRW_W'(tw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= chain_valid[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_errw_ff <= s4_errw_in;
         s4_root_ff <= fin.root[ROOT_W-1:0];
         s4_id_ff   <= fin.id;
      end
   end

   // ---------------------------------------------------------------
   // Final: penalty = err*weight*360 >> 16, add distance, saturate.
   // ---------------------------------------------------------------
   logic [PEN_W-1:0]          pen_full;
   logic [PEN_W-PEN_SHIFT-1:0] pen;
   logic [COST_W:0]           cost_sum;
   logic [COST_W-1:0]         cost;

   assign pen_full = PEN_W'(s4_errw_ff) * PEN_SCALE;
   assign pen      = pen_full[PEN_W-1:PEN_SHIFT];
   assign cost_sum = {1'b0, s4_root_ff} + (COST_W+1)'(pen);
   assign cost     = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

   // ---------------------------------------------------------------
   // Output register plus one-entry skid.
   // ---------------------------------------------------------------
   logic                out_free;
   logic [ID_W-1:0]     rsp_id_ff,    rsp_id_in;
   logic [COST_W-1:0]   rsp_cost_ff,  rsp_cost_in;
   logic [ID_W-1:0]     skid_id_ff,   skid_id_in;
   logic [COST_W-1:0]   skid_cost_ff, skid_cost_in;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_cost_in   = rsp_cost_ff;
      skid_valid_in = skid_valid_ff;
      skid_id_in    = skid_id_ff;
      skid_cost_in  = skid_cost_ff;
      priority if (skid_valid_ff) begin
         // pipe is frozen; drain the skid into the output register
         if (rsp_bus.ready) begin
            rsp_id_in     = skid_id_ff;
            rsp_cost_in   = skid_cost_ff;
            skid_valid_in = 1'b0;
         end
      end else if (s4_valid_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = s4_id_ff;
            rsp_cost_in  = cost;
         end else begin
            skid_valid_in = 1'b1;
            skid_id_in    = s4_id_ff;
            skid_cost_in  = cost;
         end
      end else begin
         if (rsp_bus.ready) begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff    <= rsp_id_in;
      rsp_cost_ff  <= rsp_cost_in;
      skid_id_ff   <= skid_id_in;
      skid_cost_ff <= skid_cost_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.scored_id   = rsp_id_ff;
   assign rsp_bus.travel_cost = rsp_cost_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // the skid only fills behind a waiting output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while output register is empty");

   // a finished beat meeting a stalled output must land in the skid
   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (!skid_valid_ff && s4_valid_ff && rsp_valid_ff && !rsp_bus.ready) |=> skid_valid_ff)
      else $error("finished beat lost at stalled output");

   // claimed tasks never enter the datapath
   a_claimed_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.already_claimed) |=> !s1_valid_ff)
      else $error("claimed task entered the pipeline");

endmodule

FILE: src/ttcs_step.sv
// One registered step: a root digit and, when enabled, a CORDIC micro-rotation.
module ttcs_step import ttcs_pkg::*; #(
   parameter int STEP   = 0,
   parameter bit ROTATE = 1'b1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           valid_in,
   input  ttcs_chain_type d,
   output logic           valid_ff,
   output ttcs_chain_type q_ff
);

   localparam logic [SQ_W-1:0]  SQRT_BIT  = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));
   localparam logic [ANG_W-1:0] ATAN_STEP = ttcs_atan(STEP);

   logic [SQ_W-1:0]      trial;
   logic                 fits;
   logic signed [CW-1:0] x_cur;
   logic signed [CW-1:0] y_cur;
   logic signed [CW-1:0] x_sh;
   logic signed [CW-1:0] y_sh;
   ttcs_chain_type       q_in;

   assign trial = d.root + SQRT_BIT;
   assign fits  = (d.rem >= trial);
   assign x_cur = d.cx;
   assign y_cur = d.cy;
   assign x_sh  = x_cur >>> STEP;
   assign y_sh  = y_cur >>> STEP;

   always_comb begin
      q_in = d;
      if (fits) begin
         q_in.rem  = d.rem - trial;
         q_in.root = (d.root >> 1) + SQRT_BIT;
      end else begin
         q_in.root = d.root >> 1;
      end
      if (ROTATE) begin
         if (y_cur > 0) begin
            q_in.cx = x_cur + y_sh;
            q_in.cy = y_cur - x_sh;
            q_in.cz = d.cz + ATAN_STEP;
         end else begin
            q_in.cx = x_cur - y_sh;
            q_in.cy = y_cur + x_sh;
            q_in.cz = d.cz - ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff <= q_in;
      end
   end

endmodule

FILE: test/task_travel_cost_scorer_unit_tb.sv
import ttcs_pkg::*;

// arctangent of 2^-i as a 32-bit binary angle; the first ARC_STEPS entries are used
localparam bit [31:0] ARC_TAN [24] = '{
   32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
   32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
   32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
   32'd166886,    32'd83443,     32'd41722,     32'd20861,
   32'd10430,     32'd5215,      32'd2608,      32'd1304,
   32'd652,       32'd326,       32'd163,       32'd81
};

localparam int ARC_STEPS = 18;

// one task to score, as driven on the request channel
typedef struct {
   logic signed [POS_W-1:0] ax;
   logic signed [POS_W-1:0] ay;
   logic [HEAD_W-1:0]       hd;
   logic signed [POS_W-1:0] tx;
   logic signed [POS_W-1:0] ty;
   logic [ID_W-1:0]         id;
   logic                    claimed;
} task_pose_type;

// one score expected on the result channel
typedef struct {
   bit [ID_W-1:0]   id;
   bit [COST_W-1:0] cost;
} score_type;

// Cost predictor plus the queue of scores still owed by the block.
class cost_board;
   int unsigned weight;
   score_type   due[$];
   int unsigned faults;

   function new();
      weight = 128;
      faults = 0;
   endfunction

   function longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // vectoring CORDIC, angle rounded to 16 bits
   function bit [15:0] bearing_of(longint dx, longint dy);
      longint  x;
      longint  y;
      longint  t;
      longint  xs;
      longint  ys;
      bit [31:0] z;
      bit [31:0] r;
      if (dx == 0 && dy == 0) return 16'h0000;
      x = dx <<< 30;
      y = dy <<< 30;
      z = '0;
      // left half plane: rotate by a quarter turn first
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = 32'h4000_0000;
         end else begin
            x = -y;
            y = t;
            z = 32'hC000_0000;
         end
      end
      for (int i = 0; i < ARC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARC_TAN[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARC_TAN[i];
         end
      end
      r = z + 32'h0000_8000;
      return r[31:16];
   endfunction

   function bit [COST_W-1:0] cost_of(task_pose_type it);
      longint          dx;
      longint          dy;
      longint unsigned span;
      longint unsigned pen;
      longint unsigned sum;
      bit [15:0]       diff;
      bit [16:0]       err;
      dx   = longint'(it.tx) - longint'(it.ax);
      dy   = longint'(it.ty) - longint'(it.ay);
      span = floor_root(longint'(unsigned'(dx * dx)) + longint'(unsigned'(dy * dy)));
      diff = bearing_of(dx, dy) - it.hd;
      // fold to 0..half turn; exactly half a turn stays 32768
      err  = diff[15] ? (17'h1_0000 - {1'b0, diff}) : {1'b0, diff};
      pen  = (64'(err) * 64'd360 * 64'(weight)) >> 16;
      sum  = span + pen;
      if (sum > 64'h1FF_FFFF) sum = 64'h1FF_FFFF;
      return sum[COST_W-1:0];
   endfunction

   function void note_task(task_pose_type it);
      score_type s;
      if (it.claimed) return;
      s.id   = it.id;
      s.cost = cost_of(it);
      due    = {due, s};
   endfunction

   function void check_score(logic [ID_W-1:0] id, logic [COST_W-1:0] cost);
      score_type s;
      if (due.size() == 0) begin
         $display("%0t: score with none pending: id %h cost %h", $time, id, cost);
         faults++;
         return;
      end
      s = due.pop_front();
      if (id !== s.id) begin
         $display("%0t: scored_id expected %h got %h", $time, s.id, id);
         faults++;
      end
      if (cost !== s.cost) begin
         $display("%0t: travel_cost expected %h got %h (id %h)", $time, s.cost, cost, s.id);
         faults++;
      end
   endfunction
endclass

module task_travel_cost_scorer_unit_tb;

   localparam int QUIET_LIMIT = 3000;   // cycles with no beat on either channel
   localparam int DRAIN_WAIT  = 40;     // pipe is 30 deep, claimed beats vanish at entry
   localparam int PHASE_ITEMS = 120;

   localparam logic signed [POS_W-1:0] P_MIN = 24'sh80_0000;
   localparam logic signed [POS_W-1:0] P_MAX = 24'sh7F_FFFF;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [TW_W-1:0] csr_write_data;

   ttcs_req_if req_bus ();
   ttcs_rsp_if rsp_bus ();

   cost_board board;

   int gap_pct;       // chance per beat of a sender gap
   int stall_pct;     // chance per cycle of a receiver stall burst
   int stall_left;
   int quiet_cycles;

   task_travel_cost_scorer_unit #(
      .CORDIC_STEPS(ARC_STEPS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: ready drops in random bursts, changed on the falling edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Result monitor: a beat moves at a rising edge with valid and ready high.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         board.check_score(rsp_bus.scored_id, rsp_bus.travel_cost);
      end
   end

   // Watchdog: any beat on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic task_pose_type pose(int ax, int ay, int hd, int tx, int ty,
                                          int id, bit claimed);
      task_pose_type it;
      it.ax      = POS_W'(ax);
      it.ay      = POS_W'(ay);
      it.hd      = HEAD_W'(hd);
      it.tx      = POS_W'(tx);
      it.ty      = POS_W'(ty);
      it.id      = ID_W'(id);
      it.claimed = claimed;
      return it;
   endfunction

   // Random task: mostly plausible geometry, headings often near the bearing
   // so the fold around zero and around the half turn both get hit.
   function automatic task_pose_type random_task();
      task_pose_type it;
      int            pick;
      int            k;
      longint        dx;
      longint        dy;
      bit [15:0]     brg;
      it.ax = POS_W'($urandom());
      it.ay = POS_W'($urandom());
      pick  = $urandom_range(0, 99);
      if (pick < 35) begin
         it.tx = POS_W'($urandom());
         it.ty = POS_W'($urandom());
      end else if (pick < 60) begin
         it.tx = POS_W'(it.ax + ($urandom_range(0, 600) - 300));
         it.ty = POS_W'(it.ay + ($urandom_range(0, 600) - 300));
      end else if (pick < 72) begin
         // on an axis, or the same point
         k = int'($urandom()) >>> $urandom_range(0, 31);
         case ($urandom_range(0, 2))
            0: begin
               it.tx = POS_W'(it.ax + k);
               it.ty = it.ay;
            end
            1: begin
               it.tx = it.ax;
               it.ty = POS_W'(it.ay + k);
            end
            default: begin
               it.tx = it.ax;
               it.ty = it.ay;
            end
         endcase
      end else begin
         it.ax = POS_W'(int'($urandom_range(0, 131072)) - 65536);
         it.ay = POS_W'(int'($urandom_range(0, 131072)) - 65536);
         it.tx = POS_W'(int'($urandom_range(0, 131072)) - 65536);
         it.ty = POS_W'(int'($urandom_range(0, 131072)) - 65536);
      end
      dx   = longint'(it.tx) - longint'(it.ax);
      dy   = longint'(it.ty) - longint'(it.ay);
      brg  = board.bearing_of(dx, dy);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         it.hd = HEAD_W'($urandom());
      end else if (pick < 70) begin
         it.hd = HEAD_W'(brg + ($urandom_range(0, 6) - 3));
      end else if (pick < 85) begin
         it.hd = HEAD_W'(brg + 16'h8000 + ($urandom_range(0, 4) - 2));
      end else begin
         case ($urandom_range(0, 3))
            0:       it.hd = 16'h0000;
            1:       it.hd = 16'hFFFF;
            2:       it.hd = 16'h8000;
            default: it.hd = 16'h7FFF;
         endcase
      end
      it.id      = ID_W'($urandom());
      it.claimed = ($urandom_range(0, 7) == 0);
      return it;
   endfunction

   // Send one beat; valid stays high across back-to-back beats.
   task automatic send_task(input task_pose_type it);
      int gap;
      gap = 0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid           <= 1'b1;
      req_bus.agent_x         <= it.ax;
      req_bus.agent_y         <= it.ay;
      req_bus.agent_heading   <= it.hd;
      req_bus.target_x        <= it.tx;
      req_bus.target_y        <= it.ty;
      req_bus.target_id       <= it.id;
      req_bus.already_claimed <= it.claimed;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      board.note_task(it);
   endtask

   // Drop valid after the last beat of a group.
   task automatic end_group();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Weight change only with the pipe empty: drain, let claimed beats clear, write.
   task automatic write_weight(input logic [TW_W-1:0] w);
      while (board.due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= w;
      @(posedge clock);
      board.weight = 32'(w);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_directed();
      task_pose_type list[$];
      // same point: bearing forced to zero, incl. the exact half-turn error
      list = {list, pose(0, 0, 16'h0000, 0, 0, 16'h0000, 1'b0)};
      list = {list, pose(0, 0, 16'h8000, 0, 0, 16'hFFFF, 1'b0)};
      list = {list, pose(P_MAX, P_MAX, 16'h1234, P_MAX, P_MAX, 16'h00A5, 1'b0)};
      // the eight compass directions, half-turn off on +x and -x
      list = {list, pose(0, 0, 16'h8000,  256,    0, 1, 1'b0)};
      list = {list, pose(0, 0, 16'h0000, -256,    0, 2, 1'b0)};
      list = {list, pose(0, 0, 16'h4000,    0,  256, 3, 1'b0)};
      list = {list, pose(0, 0, 16'hC000,    0, -256, 4, 1'b0)};
      list = {list, pose(0, 0, 16'h2000,  256,  256, 5, 1'b0)};
      list = {list, pose(0, 0, 16'h6000, -256,  256, 6, 1'b0)};
      list = {list, pose(0, 0, 16'hA000, -256, -256, 7, 1'b0)};
      list = {list, pose(0, 0, 16'hE000,  256, -256, 8, 1'b0)};
      // full-scale spans in every sign combination
      list = {list, pose(P_MIN, P_MIN, 16'h0000, P_MAX, P_MAX, 9,  1'b0)};
      list = {list, pose(P_MAX, P_MAX, 16'hFFFF, P_MIN, P_MIN, 10, 1'b0)};
      list = {list, pose(P_MIN, P_MAX, 16'h7FFF, P_MAX, P_MIN, 11, 1'b0)};
      list = {list, pose(P_MAX, P_MIN, 16'h8001, P_MIN, P_MAX, 12, 1'b0)};
      list = {list, pose(P_MIN, 0,     16'h0000, P_MAX, 0,     13, 1'b0)};
      list = {list, pose(0,     P_MIN, 16'h0000, 0,     P_MAX, 14, 1'b0)};
      // one-LSB offsets
      list = {list, pose(-1, -1, 16'h0000,  0,  0, 15, 1'b0)};
      list = {list, pose( 0,  0, 16'h0000, -1,  0, 16, 1'b0)};
      list = {list, pose( 0,  0, 16'hFFFF, -1, -1, 17, 1'b0)};
      // claimed: accepted, never scored; then one unclaimed beat behind them
      list = {list, pose(P_MIN, P_MIN, 16'h8000, P_MAX, P_MAX, 16'hFFFF, 1'b1)};
      list = {list, pose(0, 0, 16'h0000, 0, 0, 16'h0000, 1'b1)};
      list = {list, pose(0, 0, 16'h0000, 256, 0, 16'h0042, 1'b0)};
      foreach (list[i]) send_task(list[i]);
      end_group();
   endtask

   initial begin
      logic [TW_W-1:0] phase_weight [5];
      int              gap_mix      [4];
      int              stall_mix    [4];

      board        = new();
      reset        = 1'b1;
      gap_pct      = 0;
      stall_pct    = 0;
      stall_left   = 0;
      quiet_cycles = 0;

      csr_write_en            = 1'b0;
      csr_write_data          = '0;
      rsp_bus.ready           = 1'b0;
      req_bus.valid           = 1'b0;
      req_bus.agent_x         = '0;
      req_bus.agent_y         = '0;
      req_bus.agent_heading   = '0;
      req_bus.target_x        = '0;
      req_bus.target_y        = '0;
      req_bus.target_id       = '0;
      req_bus.already_claimed = 1'b0;

      // extremes first, then a random weight, the smallest nonzero one and another random weight
      phase_weight = '{10'd1023, 10'd0, 10'd0, 10'd1, 10'd0};
      phase_weight[2] = TW_W'($urandom());
      phase_weight[4] = TW_W'($urandom());
      gap_mix   = '{20, 35, 0, 50};
      stall_mix = '{35, 0, 20, 50};

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed beats at the reset weight of 0.5 m per degree
      gap_pct   = 25;
      stall_pct = 25;
      run_directed();

      for (int p = 0; p < 5; p++) begin
         write_weight(phase_weight[p]);
         // last phase runs at full rate on both sides
         gap_pct   = (p < 4) ? gap_mix[p]   : 0;
         stall_pct = (p < 4) ? stall_mix[p] : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) send_task(random_task());
         end_group();
      end

      while (board.due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (board.faults == 0 && board.due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
